### hdl/lzw_pkg.sv
// Shared constants for the LZW stream decoder.
// No dependencies; used by lzw_stream_decoder, lzw_unpack and the testbench.
`default_nettype none
package lzw_pkg;
    // parameter defaults
    localparam int TABLE_ENTRIES_DEF    = 512;
    localparam int BYTES_PER_RESULT_DEF = 8;

    // code space
    localparam int LITERALS   = 256;
    localparam int MIN_WIDTH  = 9;

    // configuration register indexes
    localparam logic [1:0] REG_WIDEN = 2'd0;
    localparam logic [1:0] REG_CLEAR = 2'd1;
    localparam logic [1:0] REG_FIRST = 2'd2;

    // configuration reset values
    localparam logic [11:0] WIDEN_RST = 12'd256;
    localparam logic [11:0] CLEAR_RST = 12'd257;
    localparam logic [11:0] FIRST_RST = 12'd258;
endpackage
`default_nettype wire

### hdl/lzw_stream_decoder.sv
// Top level of the LZW stream decoder: control sequencer, dictionary and stack RAMs.
// Uses lzw_pkg, lzw_ram and lzw_unpack.
//
// Bytes arrive one per transaction on s_, taken only while the sequencer is idle;
// a byte that completes a widen or clear code passes through the decode state, and
// a bad code waits for a free output slot. A byte that completes a data code is
// decoded in full before the next byte is taken, also while m_tready holds a result
// back: the prefix chain is walked through the dictionary RAM one entry per cycle
// (each read gives the next address), pushing onto a stack RAM, which is then popped
// one byte per cycle, pausing while each result of up to BYTES_PER_RESULT bytes is flushed.
// The dictionary and stack need no clearing after reset. Write configuration
// only while the block is idle.
`default_nettype none
module lzw_stream_decoder #(
    parameter int TABLE_ENTRIES    = lzw_pkg::TABLE_ENTRIES_DEF,
    parameter int BYTES_PER_RESULT = lzw_pkg::BYTES_PER_RESULT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [11:0] cfg_wr_data,
    // compressed input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,   // [0] stream_start
    // decoded output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,   // [63:0] out_bytes, [67:64] byte_count, rest zero
    output logic             m_tlast,   // run_last
    output logic      [0:0]  m_tuser    // [0] bad_code
);
    localparam int CW          = $clog2(TABLE_ENTRIES);
    localparam int NF_W        = CW + 1;
    localparam int DICT_DEPTH  = TABLE_ENTRIES - lzw_pkg::LITERALS;
    localparam int DA_W        = $clog2(DICT_DEPTH);
    localparam int STACK_DEPTH = TABLE_ENTRIES - lzw_pkg::LITERALS + 1;
    localparam int SA_W        = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ACNT_W      = $clog2(BYTES_PER_RESULT + 1);
    localparam int DW          = CW + 8;

    localparam logic [ACNT_W:0] BPR_V   = (ACNT_W + 1)'(BYTES_PER_RESULT);
    localparam logic [NF_W-1:0] TE_V    = NF_W'(TABLE_ENTRIES);
    localparam logic [NF_W-1:0] LIT_V   = NF_W'(lzw_pkg::LITERALS);
    localparam logic [CW-1:0]   LIT_C   = CW'(lzw_pkg::LITERALS);
    localparam logic [SP_W-1:0] SDEPTH  = SP_W'(STACK_DEPTH);
    // widest code whose whole range fits in the table
    localparam logic [4:0]      CW_V    = 5'($clog2(TABLE_ENTRIES + 1) - 1);
    localparam logic [3:0]      W_MIN   = 4'(lzw_pkg::MIN_WIDTH);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_WALK   = 3'd2;
    localparam logic [2:0] ST_POP    = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;
    localparam logic [2:0] ST_BAD    = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [11:0]       widen_reg, clear_reg, first_reg;
    logic [3:0]        cw_reg, cw_next;
    logic [NF_W-1:0]   nf_reg, nf_next;
    logic [CW-1:0]     prev_reg, prev_next;
    logic [7:0]        prev_first_reg, prev_first_next;
    logic              have_prev_reg, have_prev_next;
    logic [CW-1:0]     ent_prefix_reg, ent_prefix_next;
    logic              add_pend_reg, add_pend_next;
    logic [CW-1:0]     wx_reg, wx_next;
    logic              wpend_reg, wpend_next;
    logic [SP_W-1:0]   sp_reg, sp_next, sp_inc;
    logic [ACNT_W-1:0] acnt_reg, acnt_next, acnt_inc;
    logic [63:0]       abuf_reg, abuf_next;
    logic              rpend_reg, rpend_next;
    logic              flast_reg, flast_next;
    logic              m_valid_reg, m_valid_next;
    logic [63:0]       m_bytes_reg, m_bytes_next;
    logic [3:0]        m_cnt_reg, m_cnt_next;
    logic              m_last_reg, m_last_next;
    logic              m_bad_reg, m_bad_next;

    logic [12:0]       eff13;
    logic [NF_W-1:0]   eff_first;
    logic              s_accept, start;
    logic [3:0]        width_eff;
    logic              code_ready;
    logic [CW-1:0]     code;
    logic              code_lit, in_table, room, kwk, slot_free, issue, done;
    logic [NF_W-1:0]   code_x;
    logic [DW-1:0]     prefix_of;
    logic [CW-1:0]     rd_prefix;
    logic [7:0]        rd_last;

    logic              d_we, d_re, s_we, s_re;
    logic [DA_W-1:0]   d_waddr, d_raddr;
    logic [DW-1:0]     d_wdata, d_rdata;
    logic [SA_W-1:0]   s_waddr, s_raddr;
    logic [7:0]        s_wdata, s_rdata;

    // clamp the first free code into the table range
    always_comb begin
        eff13 = {1'b0, first_reg};
        if (first_reg < 12'(lzw_pkg::LITERALS)) begin
            eff13 = 13'(lzw_pkg::LITERALS);
        end else if ({1'b0, first_reg} > 13'(TABLE_ENTRIES)) begin
            eff13 = 13'(TABLE_ENTRIES);
        end
        eff_first = NF_W'(eff13);
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign start     = s_tuser[0];
    assign width_eff = start ? W_MIN : cw_reg;

    lzw_unpack #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_unpack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .start      (start),
        .data_byte  (s_tdata),
        .width      (width_eff),
        .code_ready (code_ready),
        .code       (code)
    );

    // dictionary: prefix code and last byte per learned entry
    lzw_ram #(
        .WIDTH (DW),
        .DEPTH (DICT_DEPTH)
    ) u_dict (
        .aclk  (aclk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (d_re),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // reverse stack of string bytes
    lzw_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign rd_prefix = d_rdata[DW-1:8];
    assign rd_last   = d_rdata[7:0];
    assign prefix_of = {prev_reg, prev_first_reg};

    // code classification
    always_comb begin
        code_x   = {1'b0, code};
        code_lit = (code < LIT_C);
        in_table = code_lit || (code_x >= eff_first && code_x < nf_reg);
        room     = nf_reg < TE_V;
        kwk      = (code_x == nf_reg) && room;
    end

    assign slot_free = !m_valid_reg || m_tready;
    assign acnt_inc  = acnt_reg + ACNT_W'(1);
    assign sp_inc    = sp_reg + SP_W'(1);
    assign issue     = (sp_reg != '0) && (({1'b0, acnt_reg} + (ACNT_W + 1)'(rpend_reg)) < BPR_V);
    assign done      = rpend_reg && (({1'b0, acnt_inc} == BPR_V) || (sp_reg == '0));

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cw_next         = cw_reg;
        nf_next         = nf_reg;
        prev_next       = prev_reg;
        prev_first_next = prev_first_reg;
        have_prev_next  = have_prev_reg;
        ent_prefix_next = ent_prefix_reg;
        add_pend_next   = add_pend_reg;
        wx_next         = wx_reg;
        wpend_next      = wpend_reg;
        sp_next         = sp_reg;
        acnt_next       = acnt_reg;
        abuf_next       = abuf_reg;
        rpend_next      = rpend_reg;
        flast_next      = flast_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_bytes_next    = m_bytes_reg;
        m_cnt_next      = m_cnt_reg;
        m_last_next     = m_last_reg;
        m_bad_next      = m_bad_reg;
        d_we            = 1'b0;
        d_waddr         = DA_W'(nf_reg - LIT_V);
        d_wdata         = {ent_prefix_reg, wx_reg[7:0]};
        d_re            = 1'b0;
        d_raddr         = DA_W'(wx_reg - LIT_C);
        s_we            = 1'b0;
        s_waddr         = SA_W'(sp_reg);
        s_wdata         = wx_reg[7:0];
        s_re            = 1'b0;
        s_raddr         = SA_W'(sp_reg - SP_W'(1));

        case (state_reg)
            ST_IDLE: begin
                // restart on a stream start, then wait for a full code
                if (s_accept) begin
                    if (start) begin
                        cw_next        = W_MIN;
                        nf_next        = eff_first;
                        prev_next      = '0;
                        have_prev_next = 1'b0;
                    end
                    if (code_ready) begin
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_DECODE: begin
                wx_next    = code;
                wpend_next = 1'b0;
                sp_next    = '0;
                if (!have_prev_reg) begin
                    if (!in_table) begin
                        state_next = ST_BAD;
                    end else begin
                        prev_next      = code;
                        have_prev_next = 1'b1;
                        add_pend_next  = 1'b0;
                        state_next     = ST_WALK;
                    end
                end else if (12'(code) == widen_reg) begin
                    if (({1'b0, cw_reg} + 5'd1) <= CW_V) begin
                        cw_next = cw_reg + 4'd1;
                    end
                    state_next = ST_IDLE;
                end else if (12'(code) == clear_reg) begin
                    cw_next        = W_MIN;
                    nf_next        = eff_first;
                    have_prev_next = 1'b0;
                    state_next     = ST_IDLE;
                end else if (!(in_table || kwk)) begin
                    state_next = ST_BAD;
                end else begin
                    ent_prefix_next = prev_reg;
                    prev_next       = code;
                    add_pend_next   = 1'b0;
                    if (kwk) begin
                        // the walk reads this entry, so write it now
                        d_we    = 1'b1;
                        d_wdata = prefix_of;
                        nf_next = nf_reg + NF_W'(1);
                    end else if (room) begin
                        add_pend_next = 1'b1;
                    end
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!wpend_reg && (wx_reg < LIT_C)) begin
                    // push the leading literal and add the deferred entry
                    s_we            = 1'b1;
                    sp_next         = sp_inc;
                    prev_first_next = wx_reg[7:0];
                    if (add_pend_reg) begin
                        d_we    = 1'b1;
                        nf_next = nf_reg + NF_W'(1);
                    end
                    add_pend_next = 1'b0;
                    acnt_next     = '0;
                    abuf_next     = '0;
                    rpend_next    = 1'b0;
                    state_next    = ST_POP;
                end else if (!wpend_reg) begin
                    d_re       = 1'b1;
                    wpend_next = 1'b1;
                end else begin
                    // push the entry's byte and follow its prefix
                    s_we    = 1'b1;
                    s_wdata = rd_last;
                    sp_next = sp_inc;
                    wx_next = rd_prefix;
                    if (sp_inc == SDEPTH) begin
                        if (add_pend_reg) begin
                            d_we    = 1'b1;
                            d_wdata = {ent_prefix_reg, rd_last};
                            nf_next = nf_reg + NF_W'(1);
                        end
                        add_pend_next = 1'b0;
                        acnt_next     = '0;
                        abuf_next     = '0;
                        rpend_next    = 1'b0;
                        state_next    = ST_POP;
                    end else if (rd_prefix < LIT_C) begin
                        wpend_next = 1'b0;
                    end else begin
                        d_re       = 1'b1;
                        d_raddr    = DA_W'(rd_prefix - LIT_C);
                        wpend_next = 1'b1;
                    end
                end
            end
            ST_POP: begin
                // append the byte read last cycle
                if (rpend_reg) begin
                    for (int k = 0; k < BYTES_PER_RESULT; k++) begin
                        if (ACNT_W'(k) == acnt_reg) begin
                            abuf_next[8*k +: 8] = s_rdata;
                        end
                    end
                    acnt_next = acnt_inc;
                end
                if (issue) begin
                    s_re    = 1'b1;
                    sp_next = sp_reg - SP_W'(1);
                end
                rpend_next = issue;
                if (done) begin
                    flast_next = (sp_reg == '0);
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_bytes_next = abuf_reg;
                    m_cnt_next   = 4'(acnt_reg);
                    m_last_next  = flast_reg;
                    m_bad_next   = 1'b0;
                    abuf_next    = '0;
                    acnt_next    = '0;
                    state_next   = flast_reg ? ST_IDLE : ST_POP;
                end
            end
            ST_BAD: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_bytes_next = '0;
                    m_cnt_next   = '0;
                    m_last_next  = 1'b1;
                    m_bad_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            widen_reg     <= lzw_pkg::WIDEN_RST;
            clear_reg     <= lzw_pkg::CLEAR_RST;
            first_reg     <= lzw_pkg::FIRST_RST;
            cw_reg        <= W_MIN;
            nf_reg        <= NF_W'(lzw_pkg::FIRST_RST);
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            add_pend_reg  <= 1'b0;
            wpend_reg     <= 1'b0;
            sp_reg        <= '0;
            acnt_reg      <= '0;
            rpend_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cw_reg        <= cw_next;
            nf_reg        <= nf_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            add_pend_reg  <= add_pend_next;
            wpend_reg     <= wpend_next;
            sp_reg        <= sp_next;
            acnt_reg      <= acnt_next;
            rpend_reg     <= rpend_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    lzw_pkg::REG_WIDEN: widen_reg <= cfg_wr_data;
                    lzw_pkg::REG_CLEAR: clear_reg <= cfg_wr_data;
                    lzw_pkg::REG_FIRST: first_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        prev_first_reg <= prev_first_next;
        ent_prefix_reg <= ent_prefix_next;
        wx_reg         <= wx_next;
        abuf_reg       <= abuf_next;
        flast_reg      <= flast_next;
        m_bytes_reg    <= m_bytes_next;
        m_cnt_reg      <= m_cnt_next;
        m_last_reg     <= m_last_next;
        m_bad_reg      <= m_bad_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_cnt_reg, m_bytes_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_bad_reg;

    // a bad-code result is a single empty final run
    a_bad_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_bad_reg |-> m_last_reg && (m_cnt_reg == 4'd0))
        else $error("bad-code result carries bytes or is not final");

    // a good result carries between one and BYTES_PER_RESULT bytes
    a_run_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_bad_reg |->
            (m_cnt_reg != 4'd0) && ({1'b0, m_cnt_reg} <= 5'(BYTES_PER_RESULT)))
        else $error("result byte count out of range");

    // the stack never overruns its depth
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SDEPTH)
        else $error("stack pointer beyond depth");

    // code width stays between nine bits and the widest code the table allows
    a_width_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw_reg >= W_MIN) && ({1'b0, cw_reg} <= CW_V))
        else $error("code width out of range");
endmodule
`default_nettype wire

### hdl/lzw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write, then registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

### hdl/lzw_unpack.sv
// Bit gatherer: collects bytes LSB first and cuts codes of the current width.
// Uses lzw_pkg.
`default_nettype none
module lzw_unpack #(
    parameter int TABLE_ENTRIES = lzw_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             accept,
    input  wire logic                             start,
    input  wire logic [7:0]                       data_byte,
    input  wire logic [3:0]                       width,
    output logic                                  code_ready,
    output logic      [$clog2(TABLE_ENTRIES)-1:0] code
);
    localparam int CW     = $clog2(TABLE_ENTRIES);
    localparam int BUF_W  = CW + 8;
    localparam int HELD_W = $clog2(BUF_W + 1);

    logic [BUF_W-1:0]  buf_reg, buf_next, base_buf, new_buf, mask;
    logic [HELD_W-1:0] held_reg, held_next, base_held, new_held;

    // merge the incoming byte above the held bits
    always_comb begin
        base_buf   = start ? '0 : buf_reg;
        base_held  = start ? '0 : held_reg;
        new_buf    = base_buf | (BUF_W'(data_byte) << base_held);
        new_held   = base_held + HELD_W'(8);
        mask       = ~({BUF_W{1'b1}} << width);
        code_ready = accept && (new_held >= HELD_W'(width));
        buf_next   = buf_reg;
        held_next  = held_reg;
        if (accept) begin
            if (code_ready) begin
                buf_next  = new_buf >> width;
                held_next = new_held - HELD_W'(width);
            end else begin
                buf_next  = new_buf;
                held_next = new_held;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg  <= '0;
            held_reg <= '0;
        end else begin
            buf_reg  <= buf_next;
            held_reg <= held_next;
        end
        // hold the cut code for the decode step
        if (code_ready) begin
            code <= CW'(new_buf & mask);
        end
    end
endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for lzw_stream_decoder: builds LZW code streams, packs them
// into bytes and compares each decoded run against an in-bench decoder model.
// Depends on lzw_pkg and the RTL under hdl.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL = lzw_pkg::TABLE_ENTRIES_DEF;
    localparam int LIT = lzw_pkg::LITERALS;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  cnt;
        logic        last;
        logic        bad;
    } run_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [11:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    lzw_stream_decoder dut (.*);

    always #2 aclk = ~aclk;

    // register copies
    logic [11:0] widen_reg = lzw_pkg::WIDEN_RST;
    logic [11:0] clear_reg = lzw_pkg::CLEAR_RST;
    logic [11:0] first_reg = lzw_pkg::FIRST_RST;

    // decoder model state
    logic [8:0]  prefix_mem [0:255];
    logic [7:0]  head_mem   [0:255];
    logic [7:0]  tail_mem   [0:255];
    logic [31:0] dec_buf;
    int          dec_held, dec_width, dec_next, dec_prev;
    bit          dec_have;

    run_t        runs_due [$];
    int          errors = 0, items_sent = 0, runs_seen = 0, bad_seen = 0;
    bit          quiet = 0;
    int          out_stall = 0;

    // encoder-side mirror used to pick codes
    logic [31:0] gen_acc;
    int          gen_bits, gen_width, gen_next;
    bit          gen_have, gen_start;

    function automatic int entry_base();
        if (first_reg < LIT) return LIT;
        if (first_reg > TBL) return TBL;
        return int'(first_reg);
    endfunction

    function automatic logic [7:0] head_of(int c);
        if (c < LIT) return c[7:0];
        if (c - LIT < TBL - LIT) return head_mem[c - LIT];
        return 8'd0;
    endfunction

    function automatic bit known_code(int c, int nxt);
        return c < LIT || (c >= entry_base() && c < nxt);
    endfunction

    // rebuild a string by walking the prefix chain, queue it as runs
    task automatic queue_string(int c);
        logic [7:0] stk [0:TBL-255];
        int n, x, k;
        run_t r;
        n = 0;
        x = c;
        forever begin
            if (x < LIT) begin
                stk[n] = x[7:0];
                n++;
                break;
            end
            if (x - LIT >= TBL - LIT) begin
                stk[n] = 8'd0;
                n++;
                break;
            end
            stk[n] = tail_mem[x - LIT];
            n++;
            if (n >= TBL - 255) break;
            x = prefix_mem[x - LIT];
        end
        while (n > 0) begin
            r = '0;
            for (k = 0; k < lzw_pkg::BYTES_PER_RESULT_DEF && n > 0; k++) begin
                n--;
                r.bytes[8*k +: 8] = stk[n];
                r.cnt++;
            end
            r.last = (n == 0);
            runs_due.push_back(r);
        end
    endtask

    task automatic queue_bad();
        run_t r;
        r = '0;
        r.last = 1'b1;
        r.bad = 1'b1;
        runs_due.push_back(r);
    endtask

    // advance the model by one accepted byte
    task automatic decode_byte(bit start, logic [7:0] b);
        int code, idx;
        if (start) begin
            dec_buf = 0; dec_held = 0; dec_width = lzw_pkg::MIN_WIDTH;
            dec_next = entry_base(); dec_prev = 0; dec_have = 0;
        end
        dec_buf |= 32'(b) << dec_held;
        dec_held += 8;
        if (dec_held < dec_width) return;
        code = int'(dec_buf & ((32'd1 << dec_width) - 1));
        dec_buf >>= dec_width;
        dec_held -= dec_width;
        if (!dec_have) begin
            if (!known_code(code, dec_next)) begin
                queue_bad();
                return;
            end
            dec_prev = code;
            dec_have = 1;
            queue_string(code);
            return;
        end
        if (code == widen_reg) begin
            if ((1 << (dec_width + 1)) <= TBL) dec_width++;
            return;
        end
        if (code == clear_reg) begin
            dec_width = lzw_pkg::MIN_WIDTH;
            dec_next = entry_base();
            dec_have = 0;
            return;
        end
        if (!(known_code(code, dec_next) || (code == dec_next && dec_next < TBL))) begin
            queue_bad();
            return;
        end
        if (dec_next < TBL && dec_next >= LIT) begin
            idx = dec_next - LIT;
            prefix_mem[idx] = dec_prev[8:0];
            head_mem[idx] = head_of(dec_prev);
            tail_mem[idx] = head_of(code);
            dec_next++;
        end
        dec_prev = code;
        queue_string(code);
    endtask

    // drive one byte, hold it until the transaction completes
    task automatic send_byte(bit start, logic [7:0] b);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= start;
        do @(posedge aclk); while (!s_tready);
        decode_byte(start, b);
        items_sent++;
    endtask

    task automatic start_stream();
        gen_acc = 0; gen_bits = 0; gen_width = lzw_pkg::MIN_WIDTH;
        gen_next = entry_base(); gen_have = 0; gen_start = 1;
    endtask

    // append one code to the bit stream, send whole bytes
    task automatic put_code(int c);
        c = c & ((1 << gen_width) - 1);
        gen_acc |= 32'(c) << gen_bits;
        gen_bits += gen_width;
        if (!gen_have) begin
            if (known_code(c, gen_next)) gen_have = 1;
        end else if (c == widen_reg) begin
            if ((1 << (gen_width + 1)) <= TBL) gen_width++;
        end else if (c == clear_reg) begin
            gen_width = lzw_pkg::MIN_WIDTH;
            gen_next = entry_base();
            gen_have = 0;
        end else if (known_code(c, gen_next) || (c == gen_next && gen_next < TBL)) begin
            if (gen_next < TBL && gen_next >= LIT) gen_next++;
        end
        while (gen_bits >= 8) begin
            send_byte(gen_start, gen_acc[7:0]);
            gen_start = 0;
            gen_acc >>= 8;
            gen_bits -= 8;
        end
    endtask

    // pad the tail of a stream out to a whole byte
    task automatic end_stream();
        if (gen_bits > 0) begin
            send_byte(gen_start, gen_acc[7:0]);
            gen_start = 0;
            gen_bits = 0;
        end
    endtask

    // pick a code: mostly well formed, some specials and noise
    function automatic int pick_code(bit no_specials);
        int r, top;
        r = $urandom_range(0, 99);
        top = (1 << gen_width) - 1;
        if (!gen_have) return (r < 90) ? $urandom_range(0, 255) : $urandom_range(0, top);
        if (no_specials) r = $urandom_range(0, 82);
        if (r >= 40 && r < 75 && gen_next > entry_base())
            return $urandom_range(entry_base(), gen_next - 1);
        if (r >= 75 && r < 83 && gen_next < TBL) return gen_next;
        if (r >= 83 && r < 87) return int'(clear_reg);
        if (r >= 87 && r < 90) return int'(widen_reg);
        if (r >= 90 && r < 95) return $urandom_range(0, top);
        return $urandom_range(0, 255);
    endfunction

    task automatic random_stream(int codes, bit no_specials);
        start_stream();
        repeat (codes) put_code(pick_code(no_specials));
        end_stream();
    endtask

    // let the block go idle, then write one register
    task automatic write_reg(logic [1:0] a, logic [11:0] v);
        s_tvalid <= 1'b0;
        wait (runs_due.size() == 0);
        repeat (100) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (a)
            lzw_pkg::REG_WIDEN: widen_reg = v;
            lzw_pkg::REG_CLEAR: clear_reg = v;
            default:            first_reg = v;
        endcase
    endtask

    // literals at both ends, a code equal to the next entry, widen, clear,
    // bad first code after clear, a special code as first code
    task automatic test_directed();
        start_stream();
        put_code(0);
        put_code(255);
        put_code(entry_base());
        put_code(entry_base() + 1);
        put_code(int'(widen_reg));
        put_code(65);
        put_code(int'(clear_reg));
        put_code(300);
        put_code(66);
        put_code(400);
        put_code(int'(clear_reg));
        put_code(int'(widen_reg));
        put_code(255);
        put_code(255);
        put_code(entry_base());
        end_stream();
        start_stream();
        put_code(511);
        put_code(7);
        put_code(0);
        end_stream();
    endtask

    // widen and clear share one code
    task automatic test_shared_special();
        write_reg(lzw_pkg::REG_WIDEN, 12'd260);
        write_reg(lzw_pkg::REG_CLEAR, 12'd260);
        repeat (2) random_stream($urandom_range(15, 25), 0);
    endtask

    // first free below the literal range, specials at the extremes
    task automatic test_low_first();
        write_reg(lzw_pkg::REG_FIRST, 12'd0);
        write_reg(lzw_pkg::REG_WIDEN, 12'd0);
        write_reg(lzw_pkg::REG_CLEAR, 12'd4095);
        repeat (2) random_stream($urandom_range(15, 25), 0);
    endtask

    // first free above the table: nothing is ever learned
    task automatic test_high_first();
        write_reg(lzw_pkg::REG_FIRST, 12'd4095);
        write_reg(lzw_pkg::REG_WIDEN, 12'd4095);
        write_reg(lzw_pkg::REG_CLEAR, 12'd0);
        random_stream(20, 0);
    endtask

    // fill the table up from a high first free entry and keep decoding
    task automatic test_full_table();
        write_reg(lzw_pkg::REG_FIRST, 12'd400);
        write_reg(lzw_pkg::REG_WIDEN, lzw_pkg::WIDEN_RST);
        write_reg(lzw_pkg::REG_CLEAR, 12'd4095);
        random_stream(TBL - 400 + 30, 1);
    endtask

    // random streams at reset settings, no idling at the end
    task automatic test_random();
        write_reg(lzw_pkg::REG_FIRST, lzw_pkg::FIRST_RST);
        write_reg(lzw_pkg::REG_CLEAR, lzw_pkg::CLEAR_RST);
        while (items_sent < 360) random_stream($urandom_range(10, 30), 0);
        quiet = 1;
        while (items_sent < 400) random_stream($urandom_range(10, 30), 0);
    endtask

    // output side: random stalls and result checking
    always @(posedge aclk) begin
        run_t want;
        if (aresetn) begin
            if (out_stall > 0) begin
                out_stall <= out_stall - 1;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_stall <= $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            if (m_tvalid && m_tready) begin
                runs_seen++;
                if (runs_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected run, actual data %h last %b bad %b",
                             $realtime, m_tdata, m_tlast, m_tuser);
                end else begin
                    want = runs_due.pop_front();
                    if (want.bad) bad_seen++;
                    if (m_tdata !== {4'd0, want.cnt, want.bytes} || m_tlast !== want.last ||
                        m_tuser[0] !== want.bad) begin
                        errors++;
                        $display("%0t: mismatch, expected data %h last %b bad %b",
                                 $realtime, {4'd0, want.cnt, want.bytes}, want.last, want.bad);
                        $display("%0t:           actual data %h last %b bad %b",
                                 $realtime, m_tdata, m_tlast, m_tuser);
                    end
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_shared_special();
        test_low_first();
        test_high_first();
        test_full_table();
        test_random();
        s_tvalid <= 1'b0;
        wait (runs_due.size() == 0);
        repeat (100) @(posedge aclk);
        $display("Decoded %0d bytes into %0d runs (%0d flagged bad) over six register settings.",
                 items_sent, runs_seen, bad_seen);
        if (errors == 0 && runs_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("Timed out with %0d runs outstanding.", runs_due.size());
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
hdl/lzw_pkg.sv
hdl/lzw_ram.sv
hdl/lzw_unpack.sv
hdl/lzw_stream_decoder.sv
test/testbench.sv
